FILE: hdl/ehc_pkg.sv
// Package for the Ethernet header classifier.
// Holds the frame kind and status codes and the header constants.
// No dependencies.
package ehc_pkg;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETHERTYPE_ARP  = 16'h0806;

  localparam logic [7:0]  PROTO_ICMP = 8'd1;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;

  localparam logic [15:0] ARP_OP_REQUEST = 16'd1;
  localparam logic [15:0] ARP_OP_REPLY   = 16'd2;

  localparam int unsigned ETH_HDR_BYTES = 14;
  localparam int unsigned IPV4_MIN_LEN  = 34;
  localparam int unsigned ARP_MIN_LEN   = 22;
  localparam int unsigned ARP_REQ_LEN   = 42;
  localparam int unsigned ARP_REP_LEN   = 32;
  localparam int unsigned TCP_NEED      = 14;
  localparam int unsigned UDP_NEED      = 4;
  localparam int unsigned ICMP_NEED     = 2;
  localparam int unsigned TCP_FLAGS_REL = 13;
  localparam logic [3:0]  IHL_MIN       = 4'd5;

  typedef enum logic [2:0] {
    KIND_TCP        = 3'd0,
    KIND_UDP        = 3'd1,
    KIND_ICMP       = 3'd2,
    KIND_IPV4_OTHER = 3'd3,
    KIND_ARP_REQ    = 3'd4,
    KIND_ARP_REPLY  = 3'd5,
    KIND_ARP_OTHER  = 3'd6,
    KIND_UNKNOWN    = 3'd7
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_SHORT = 2'd1,
    STATUS_IHL   = 2'd2,
    STATUS_RSVD  = 2'd3
  } status_e;

endpackage

FILE: hdl/ethernet_header_classifier.sv
// Ethernet header classifier: byte-wide frame parser giving one summary per frame.
// Depends on ehc_pkg.
//
// Takes one frame byte per transfer, with frame_end_i on the last byte, and
// returns one summary per frame: ethertype class, IPv4 or ARP addresses, IPv4
// length, id, TCP/UDP ports, TCP flags, ICMP type and code, ARP sender MAC and
// a status. Every byte goes through an input register and one pass of field
// capture into the header registers, so a byte is taken every cycle but for
// stalls; the summary is registered as its last byte leaves the input register.
// Input only stalls when a last byte meets a summary still waiting at the output.
module ethernet_header_classifier (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  frame_byte_i,
  input  logic        frame_end_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  frame_kind_o,
  output logic [31:0] source_address_o,
  output logic [31:0] target_address_o,
  output logic [15:0] total_length_o,
  output logic [15:0] datagram_id_o,
  output logic [15:0] source_port_o,
  output logic [15:0] destination_port_o,
  output logic [5:0]  control_bits_o,
  output logic [7:0]  message_type_o,
  output logic [7:0]  message_code_o,
  output logic [47:0] sender_hw_address_o,
  output logic [1:0]  status_o
);

  // input register
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_end_q;
  logic       s1_go;

  // header state
  logic [15:0] pos_q;
  logic [15:0] ether_q, ether_d;
  logic [3:0]  ihl_q, ihl_d;
  logic [7:0]  proto_q, proto_d;
  logic [15:0] arp_op_q, arp_op_d;
  logic [31:0] src_q, src_d;
  logic [31:0] dst_q, dst_d;
  logic [15:0] tot_len_q, tot_len_d;
  logic [15:0] id_q, id_d;
  logic [31:0] l4_q, l4_d;
  logic [5:0]  flags_q, flags_d;
  logic [47:0] sha_q, sha_d;

  logic [15:0] l4_off;

  // result register
  logic              out_valid_q;
  ehc_pkg::kind_e    kind_d, kind_q;
  ehc_pkg::status_e  status_d, status_q;
  logic [31:0]       r_src_d, r_src_q;
  logic [31:0]       r_dst_d, r_dst_q;
  logic [15:0]       r_tot_d, r_tot_q;
  logic [15:0]       r_id_d, r_id_q;
  logic [15:0]       r_sport_d, r_sport_q;
  logic [15:0]       r_dport_d, r_dport_q;
  logic [5:0]        r_flags_d, r_flags_q;
  logic [7:0]        r_mtype_d, r_mtype_q;
  logic [7:0]        r_mcode_d, r_mcode_q;
  logic [47:0]       r_sha_d, r_sha_q;

  logic [16:0] len;
  logic [16:0] need;

  assign s1_go      = s1_valid_q && (!s1_end_q || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_go;

  assign l4_off = 16'(ehc_pkg::ETH_HDR_BYTES) + {10'd0, ihl_d, 2'b00};

  // field capture for the byte in the input register
  always_comb begin
    ether_d   = ether_q;
    ihl_d     = ihl_q;
    proto_d   = proto_q;
    arp_op_d  = arp_op_q;
    src_d     = src_q;
    dst_d     = dst_q;
    tot_len_d = tot_len_q;
    id_d      = id_q;
    l4_d      = l4_q;
    flags_d   = flags_q;
    sha_d     = sha_q;
    case (pos_q)
      16'd12:  ether_d[15:8] = s1_byte_q;
      16'd13:  ether_d[7:0]  = s1_byte_q;
      default: ;
    endcase
    if (pos_q >= 16'(ehc_pkg::ETH_HDR_BYTES)) begin
      if (ether_q == ehc_pkg::ETHERTYPE_IPV4) begin
        case (pos_q)
          16'd14:  ihl_d           = s1_byte_q[3:0];
          16'd16:  tot_len_d[15:8] = s1_byte_q;
          16'd17:  tot_len_d[7:0]  = s1_byte_q;
          16'd18:  id_d[15:8]      = s1_byte_q;
          16'd19:  id_d[7:0]       = s1_byte_q;
          16'd23:  proto_d         = s1_byte_q;
          16'd26:  src_d[31:24]    = s1_byte_q;
          16'd27:  src_d[23:16]    = s1_byte_q;
          16'd28:  src_d[15:8]     = s1_byte_q;
          16'd29:  src_d[7:0]      = s1_byte_q;
          16'd30:  dst_d[31:24]    = s1_byte_q;
          16'd31:  dst_d[23:16]    = s1_byte_q;
          16'd32:  dst_d[15:8]     = s1_byte_q;
          16'd33:  dst_d[7:0]      = s1_byte_q;
          default: ;
        endcase
        if (pos_q > 16'd14 && ihl_q >= ehc_pkg::IHL_MIN) begin
          if (pos_q == l4_off)         l4_d[31:24] = s1_byte_q;
          if (pos_q == l4_off + 16'd1) l4_d[23:16] = s1_byte_q;
          if (pos_q == l4_off + 16'd2) l4_d[15:8]  = s1_byte_q;
          if (pos_q == l4_off + 16'd3) l4_d[7:0]   = s1_byte_q;
          if (pos_q == l4_off + 16'(ehc_pkg::TCP_FLAGS_REL)) flags_d = s1_byte_q[5:0];
        end
      end else if (ether_q == ehc_pkg::ETHERTYPE_ARP) begin
        case (pos_q)
          16'd20:  arp_op_d[15:8] = s1_byte_q;
          16'd21:  arp_op_d[7:0]  = s1_byte_q;
          16'd22:  sha_d[47:40]   = s1_byte_q;
          16'd23:  sha_d[39:32]   = s1_byte_q;
          16'd24:  sha_d[31:24]   = s1_byte_q;
          16'd25:  sha_d[23:16]   = s1_byte_q;
          16'd26:  sha_d[15:8]    = s1_byte_q;
          16'd27:  sha_d[7:0]     = s1_byte_q;
          16'd28:  src_d[31:24]   = s1_byte_q;
          16'd29:  src_d[23:16]   = s1_byte_q;
          16'd30:  src_d[15:8]    = s1_byte_q;
          16'd31:  src_d[7:0]     = s1_byte_q;
          16'd38:  dst_d[31:24]   = s1_byte_q;
          16'd39:  dst_d[23:16]   = s1_byte_q;
          16'd40:  dst_d[15:8]    = s1_byte_q;
          16'd41:  dst_d[7:0]     = s1_byte_q;
          default: ;
        endcase
      end
    end
  end

  // summary from the captured fields including the last byte
  assign len = {1'b0, pos_q} + 17'd1;

  always_comb begin
    kind_d    = ehc_pkg::KIND_UNKNOWN;
    status_d  = ehc_pkg::STATUS_OK;
    need      = 17'(ehc_pkg::IPV4_MIN_LEN);
    r_src_d   = '0;
    r_dst_d   = '0;
    r_tot_d   = '0;
    r_id_d    = '0;
    r_sport_d = '0;
    r_dport_d = '0;
    r_flags_d = '0;
    r_mtype_d = '0;
    r_mcode_d = '0;
    r_sha_d   = '0;
    if (len < 17'(ehc_pkg::ETH_HDR_BYTES)) begin
      status_d = ehc_pkg::STATUS_SHORT;
    end else if (ether_d == ehc_pkg::ETHERTYPE_IPV4) begin
      case (proto_d)
        ehc_pkg::PROTO_TCP: begin
          kind_d = ehc_pkg::KIND_TCP;
          need   = {1'b0, l4_off} + 17'(ehc_pkg::TCP_NEED);
        end
        ehc_pkg::PROTO_UDP: begin
          kind_d = ehc_pkg::KIND_UDP;
          need   = {1'b0, l4_off} + 17'(ehc_pkg::UDP_NEED);
        end
        ehc_pkg::PROTO_ICMP: begin
          kind_d = ehc_pkg::KIND_ICMP;
          need   = {1'b0, l4_off} + 17'(ehc_pkg::ICMP_NEED);
        end
        default: kind_d = ehc_pkg::KIND_IPV4_OTHER;
      endcase
      r_src_d = src_d;
      r_dst_d = dst_d;
      r_tot_d = tot_len_d;
      r_id_d  = id_d;
      if (len < 17'(ehc_pkg::IPV4_MIN_LEN)) status_d = ehc_pkg::STATUS_SHORT;
      else if (ihl_d < ehc_pkg::IHL_MIN)     status_d = ehc_pkg::STATUS_IHL;
      else if (len < need)                   status_d = ehc_pkg::STATUS_SHORT;
      if (ihl_d >= ehc_pkg::IHL_MIN) begin
        if (kind_d == ehc_pkg::KIND_TCP || kind_d == ehc_pkg::KIND_UDP) begin
          r_sport_d = l4_d[31:16];
          r_dport_d = l4_d[15:0];
        end
        if (kind_d == ehc_pkg::KIND_TCP) r_flags_d = flags_d;
        if (kind_d == ehc_pkg::KIND_ICMP) begin
          r_mtype_d = l4_d[31:24];
          r_mcode_d = l4_d[23:16];
        end
      end
    end else if (ether_d == ehc_pkg::ETHERTYPE_ARP) begin
      if (arp_op_d == ehc_pkg::ARP_OP_REQUEST) begin
        kind_d = ehc_pkg::KIND_ARP_REQ;
        need   = 17'(ehc_pkg::ARP_REQ_LEN);
      end else if (arp_op_d == ehc_pkg::ARP_OP_REPLY) begin
        kind_d = ehc_pkg::KIND_ARP_REPLY;
        need   = 17'(ehc_pkg::ARP_REP_LEN);
      end else begin
        kind_d = ehc_pkg::KIND_ARP_OTHER;
        need   = 17'(ehc_pkg::ARP_MIN_LEN);
      end
      if (len < 17'(ehc_pkg::ARP_MIN_LEN) || len < need) status_d = ehc_pkg::STATUS_SHORT;
      r_src_d = src_d;
      r_dst_d = dst_d;
      r_sha_d = sha_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pos_q       <= '0;
      ether_q     <= '0;
      ihl_q       <= '0;
      proto_q     <= '0;
      arp_op_q    <= '0;
      src_q       <= '0;
      dst_q       <= '0;
      tot_len_q   <= '0;
      id_q        <= '0;
      l4_q        <= '0;
      flags_q     <= '0;
      sha_q       <= '0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s1_go && s1_end_q) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (s1_go) begin
        if (s1_end_q) begin
          pos_q     <= '0;
          ether_q   <= '0;
          ihl_q     <= '0;
          proto_q   <= '0;
          arp_op_q  <= '0;
          src_q     <= '0;
          dst_q     <= '0;
          tot_len_q <= '0;
          id_q      <= '0;
          l4_q      <= '0;
          flags_q   <= '0;
          sha_q     <= '0;
        end else begin
          if (pos_q != 16'hffff) pos_q <= pos_q + 16'd1;
          ether_q   <= ether_d;
          ihl_q     <= ihl_d;
          proto_q   <= proto_d;
          arp_op_q  <= arp_op_d;
          src_q     <= src_d;
          dst_q     <= dst_d;
          tot_len_q <= tot_len_d;
          id_q      <= id_d;
          l4_q      <= l4_d;
          flags_q   <= flags_d;
          sha_q     <= sha_d;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_byte_q <= frame_byte_i;
      s1_end_q  <= frame_end_i;
    end
    if (s1_go && s1_end_q) begin
      kind_q    <= kind_d;
      status_q  <= status_d;
      r_src_q   <= r_src_d;
      r_dst_q   <= r_dst_d;
      r_tot_q   <= r_tot_d;
      r_id_q    <= r_id_d;
      r_sport_q <= r_sport_d;
      r_dport_q <= r_dport_d;
      r_flags_q <= r_flags_d;
      r_mtype_q <= r_mtype_d;
      r_mcode_q <= r_mcode_d;
      r_sha_q   <= r_sha_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign frame_kind_o        = kind_q;
  assign status_o            = status_q;
  assign source_address_o    = r_src_q;
  assign target_address_o    = r_dst_q;
  assign total_length_o      = r_tot_q;
  assign datagram_id_o       = r_id_q;
  assign source_port_o       = r_sport_q;
  assign destination_port_o  = r_dport_q;
  assign control_bits_o      = r_flags_q;
  assign message_type_o      = r_mtype_q;
  assign message_code_o      = r_mcode_q;
  assign sender_hw_address_o = r_sha_q;

endmodule
